@@ sv/tgr_pkg.sv @@
// Shared types, constants and helper functions of the text glyph rect generator.
// No dependencies; the design modules and the testbench import this package, the two interfaces do not.
package tgr_pkg;

    localparam int GLYPH_ROWS      = 7;
    localparam int GLYPH_COLS      = 5;
    localparam int GLYPH_BITS      = GLYPH_ROWS * GLYPH_COLS;
    localparam int ROW_W           = 3;
    localparam int COL_W           = 3;
    localparam int CLIP_BUFFER_DEF = 256;
    localparam int FONT_SPAN       = 96;
    localparam int FONT_AW         = 7;
    localparam int LIM_W           = 12;
    localparam int ADV_W           = 7;
    localparam int PADDR_W         = 5;
    localparam int REG_IDX_W       = 3;
    localparam int COUNT_W         = 9;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_SCALE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FIT_ENABLE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AVAIL_WIDTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DRAW_COLOR  = 3'd5;

    // Character codes with a special meaning
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MARKER  = 8'h3E;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] CH_SPAN    = 8'd96;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

    typedef enum logic [1:0] {
        GLYPH_ROM,
        GLYPH_BOX,
        GLYPH_BLANK
    } glyph_src_t;

    typedef struct packed {
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [3:0]         pixel_scale;
        logic               fit_enable;
        logic [11:0]        avail_width;
        logic [31:0]        draw_color;
        logic [ADV_W-1:0]   advance;
        logic [LIM_W-1:0]   limit;
        logic               div_busy;
    } cfg_t;

    typedef struct packed {
        logic                  valid;
        logic signed [15:0]    pen_x;
        logic signed [11:0]    origin_y;
        logic [3:0]            pixel_scale;
        logic [31:0]           draw_color;
        glyph_src_t            src;
        logic                  drop;
        logic [GLYPH_BITS-1:0] glyph;
    } glyph_job_t;

    // Pack seven 5-bit rows, row 0 in the low bits
    function automatic logic [GLYPH_BITS-1:0] pack_rows(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6);
        return {r6, r5, r4, r3, r2, r1, r0};
    endfunction

    localparam logic [GLYPH_BITS-1:0] BOX_GLYPH =
        pack_rows(5'd31, 5'd17, 5'd5, 5'd2, 5'd4, 5'd0, 5'd4);

    // Font ROM contents; unlisted codes are empty
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [FONT_AW-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            7'h30: g = pack_rows(5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14);
            7'h31: g = pack_rows(5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            7'h32: g = pack_rows(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31);
            7'h33: g = pack_rows(5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30);
            7'h34: g = pack_rows(5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2);
            7'h35: g = pack_rows(5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14);
            7'h36: g = pack_rows(5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14);
            7'h37: g = pack_rows(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8);
            7'h38: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14);
            7'h39: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12);
            7'h41: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            7'h42: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30);
            7'h43: g = pack_rows(5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14);
            7'h44: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30);
            7'h45: g = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31);
            7'h46: g = pack_rows(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16);
            7'h47: g = pack_rows(5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15);
            7'h48: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17);
            7'h49: g = pack_rows(5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            7'h4A: g = pack_rows(5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12);
            7'h4B: g = pack_rows(5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17);
            7'h4C: g = pack_rows(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31);
            7'h4D: g = pack_rows(5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17);
            7'h4E: g = pack_rows(5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17);
            7'h4F: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            7'h50: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16);
            7'h51: g = pack_rows(5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13);
            7'h52: g = pack_rows(5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17);
            7'h53: g = pack_rows(5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30);
            7'h54: g = pack_rows(5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4);
            7'h55: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14);
            7'h56: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4);
            7'h57: g = pack_rows(5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10);
            7'h58: g = pack_rows(5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17);
            7'h59: g = pack_rows(5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4);
            7'h5A: g = pack_rows(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31);
            7'h3F: g = pack_rows(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd0,  5'd4);
            7'h2E: g = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd12);
            7'h2F: g = pack_rows(5'd1,  5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd16);
            7'h5C: g = pack_rows(5'd16, 5'd16, 5'd8,  5'd4,  5'd2,  5'd1,  5'd1);
            7'h2B: g = pack_rows(5'd0,  5'd4,  5'd4,  5'd31, 5'd4,  5'd4,  5'd0);
            7'h2D: g = pack_rows(5'd0,  5'd0,  5'd0,  5'd31, 5'd0,  5'd0,  5'd0);
            7'h5F: g = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd31);
            7'h3A: g = pack_rows(5'd0,  5'd12, 5'd12, 5'd0,  5'd12, 5'd12, 5'd0);
            7'h26: g = pack_rows(5'd12, 5'd18, 5'd20, 5'd8,  5'd21, 5'd18, 5'd13);
            7'h5B: g = pack_rows(5'd14, 5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd14);
            7'h5D: g = pack_rows(5'd14, 5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd14);
            7'h28: g = pack_rows(5'd2,  5'd4,  5'd8,  5'd8,  5'd8,  5'd4,  5'd2);
            7'h29: g = pack_rows(5'd8,  5'd4,  5'd2,  5'd2,  5'd2,  5'd4,  5'd8);
            7'h3C: g = pack_rows(5'd2,  5'd4,  5'd8,  5'd16, 5'd8,  5'd4,  5'd2);
            7'h3E: g = pack_rows(5'd8,  5'd4,  5'd2,  5'd1,  5'd2,  5'd4,  5'd8);
            7'h3D: g = pack_rows(5'd0,  5'd0,  5'd31, 5'd0,  5'd31, 5'd0,  5'd0);
            7'h2C: g = pack_rows(5'd0,  5'd0,  5'd0,  5'd0,  5'd12, 5'd4,  5'd8);
            default: g = '0;
        endcase
        return g;
    endfunction

    // Clamp a 17-bit signed sum to the 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v[16] != v[15])
        begin
            r = v[16] ? 16'sh8000 : 16'sh7fff;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ sv/tgr_char_if.sv @@
// Character input channel: one word carries a character code and a string start flag.
// Standalone; no package needed.
interface tgr_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       string_start;

    modport source (output valid, output char_code, output string_start, input ready);
    modport sink   (input valid, input char_code, input string_start, output ready);
endinterface

@@ sv/tgr_rect_if.sv @@
// Square output channel: one word carries one filled square.
// Standalone; no package needed.
interface tgr_rect_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [3:0]         rect_size;
    logic [31:0]        fill_color;
    logic               last_rect;

    modport source (output valid, output rect_x, output rect_y, output rect_size,
                    output fill_color, output last_rect, input ready);
    modport sink   (input valid, input rect_x, input rect_y, input rect_size,
                    input fill_color, input last_rect, output ready);
endinterface

@@ sv/tgr_cfg.sv @@
// APB register file and the iterative fit-limit divider (fit width / (6 * scale)).
// Depends on tgr_pkg.
module tgr_cfg
    import tgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    localparam int DIV_CW = $clog2(LIM_W + 1);
    localparam logic [DIV_CW-1:0] DIV_STEPS = DIV_CW'(LIM_W);

    logic signed [11:0]  origin_x_reg;
    logic signed [11:0]  origin_y_reg;
    logic [3:0]          pixel_scale_reg;
    logic                fit_enable_reg;
    logic [11:0]         avail_width_reg;
    logic [31:0]         draw_color_reg;

    logic [DIV_CW-1:0]   div_cnt_reg, div_cnt_next;
    logic [ADV_W-1:0]    div_rem_reg, div_rem_next;
    logic [LIM_W-1:0]    div_q_reg, div_q_next;

    logic                 wr;
    logic [REG_IDX_W-1:0] wr_idx;
    logic                 div_start;
    logic [ADV_W-1:0]     advance;
    logic [ADV_W:0]       trial;
    logic [ADV_W+1:0]     diff;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign wr_idx = paddr[PADDR_W-1:2];

    // Pen advance: 6 * scale
    assign advance = {1'b0, pixel_scale_reg, 2'b00} + {2'b00, pixel_scale_reg, 1'b0};

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            pixel_scale_reg <= 4'd1;
            fit_enable_reg  <= 1'b0;
            avail_width_reg <= '0;
            draw_color_reg  <= 32'hFFFF_FFFF;
        end
        else if (wr)
        begin
            case (wr_idx)
                REG_ORIGIN_X:    origin_x_reg    <= pwdata[11:0];
                REG_ORIGIN_Y:    origin_y_reg    <= pwdata[11:0];
                REG_PIXEL_SCALE: pixel_scale_reg <= pwdata[3:0];
                REG_FIT_ENABLE:  fit_enable_reg  <= pwdata[0];
                REG_AVAIL_WIDTH: avail_width_reg <= pwdata[11:0];
                REG_DRAW_COLOR:  draw_color_reg  <= pwdata;
                default:         ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (wr_idx)
            REG_ORIGIN_X:    prdata = {20'd0, origin_x_reg};
            REG_ORIGIN_Y:    prdata = {20'd0, origin_y_reg};
            REG_PIXEL_SCALE: prdata = {28'd0, pixel_scale_reg};
            REG_FIT_ENABLE:  prdata = {31'd0, fit_enable_reg};
            REG_AVAIL_WIDTH: prdata = {20'd0, avail_width_reg};
            REG_DRAW_COLOR:  prdata = draw_color_reg;
            default:         prdata = '0;
        endcase
    end

    // Restart the divider whenever an operand changes
    assign div_start = wr && (wr_idx == REG_PIXEL_SCALE || wr_idx == REG_AVAIL_WIDTH);

    // One quotient bit per cycle, restoring
    always_comb
    begin
        trial        = {div_rem_reg, div_q_reg[LIM_W-1]};
        diff         = {1'b0, trial} - {2'b00, advance};
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        if (div_start)
        begin
            div_cnt_next = DIV_STEPS;
            div_rem_next = '0;
            div_q_next   = (wr_idx == REG_AVAIL_WIDTH) ? pwdata[LIM_W-1:0] : avail_width_reg;
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            if (!diff[ADV_W+1])
            begin
                div_rem_next = diff[ADV_W-1:0];
                div_q_next   = {div_q_reg[LIM_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = trial[ADV_W-1:0];
                div_q_next   = {div_q_reg[LIM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end
        else
        begin
            div_cnt_reg <= div_cnt_next;
            div_rem_reg <= div_rem_next;
            div_q_reg   <= div_q_next;
        end
    end

    always_comb
    begin
        cfg.origin_x    = origin_x_reg;
        cfg.origin_y    = origin_y_reg;
        cfg.pixel_scale = pixel_scale_reg;
        cfg.fit_enable  = fit_enable_reg;
        cfg.avail_width = avail_width_reg;
        cfg.draw_color  = draw_color_reg;
        cfg.advance     = advance;
        cfg.limit       = div_q_reg;
        cfg.div_busy    = (div_cnt_reg != '0);
    end

endmodule

@@ sv/tgr_front.sv @@
// Accept stage: pen and count state, fit clipping, case folding and the font ROM read.
// Depends on tgr_pkg and tgr_char_if.
module tgr_front
    import tgr_pkg::*;
#(
    parameter int CLIP_BUFFER = CLIP_BUFFER_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    tgr_char_if.sink   char_in,
    input  cfg_t       cfg,
    output glyph_job_t job,
    input  logic       job_ready
);

    localparam int CAP_W = $clog2(CLIP_BUFFER);
    localparam int CMP_W = ((CAP_W > LIM_W) ? CAP_W : LIM_W) + 1;
    localparam logic [CMP_W-1:0] CAP = CMP_W'(CLIP_BUFFER - 1);

    logic signed [15:0]    pen_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic                  s1_valid_reg;
    logic signed [15:0]    s1_pen_reg;
    logic signed [11:0]    s1_oy_reg;
    logic [3:0]            s1_sc_reg;
    logic [31:0]           s1_color_reg;
    glyph_src_t            s1_src_reg;
    logic                  s1_drop_reg;
    logic [GLYPH_BITS-1:0] rom_data_reg;

    logic                  in_ready;
    logic                  take;
    logic [COUNT_W-1:0]    pos;
    logic [COUNT_W-1:0]    count_next;
    logic signed [15:0]    pen_use;
    logic signed [15:0]    pen_next;
    logic [CMP_W-1:0]      lim_ext, lim_cap, pos_ext;
    logic                  drop, marker;
    logic [7:0]            code_eff, code_fold;
    glyph_src_t            src;

    // Hold input while the divider settles or the next stage is full
    assign in_ready      = (!s1_valid_reg || job_ready) && !cfg.div_busy;
    assign char_in.ready = in_ready;
    assign take          = char_in.valid && in_ready;

    // Pen and count seen by this word
    assign pos        = char_in.string_start ? '0 : count_reg;
    assign pen_use    = char_in.string_start ? {{4{cfg.origin_x[11]}}, cfg.origin_x} : pen_reg;
    assign count_next = (pos != COUNT_MAX) ? pos + 1'b1 : pos;

    // Fit clipping against the capped limit
    always_comb
    begin
        lim_ext = CMP_W'(cfg.limit);
        lim_cap = (lim_ext > CAP) ? CAP : lim_ext;
        pos_ext = CMP_W'(pos);
        drop    = cfg.fit_enable && (cfg.avail_width == '0 || cfg.pixel_scale == '0 ||
                                     lim_cap == '0 || pos_ext >= lim_cap);
        marker  = cfg.fit_enable && (lim_cap > CMP_W'(1)) && (pos_ext == lim_cap - 1'b1);
    end

    // Advance pen unless the character is clipped
    assign pen_next = drop ? pen_use
                           : sat16({pen_use[15], pen_use} + {10'd0, cfg.advance});

    // Fold to upper case and classify
    always_comb
    begin
        code_eff  = marker ? CH_MARKER : char_in.char_code;
        code_fold = (code_eff >= CH_LOWER_A && code_eff <= CH_LOWER_Z) ? code_eff - CASE_FOLD
                                                                       : code_eff;
        if (code_fold >= CH_SPAN)
        begin
            src = GLYPH_BOX;
        end
        else if (code_fold == CH_SPACE)
        begin
            src = GLYPH_BLANK;
        end
        else
        begin
            src = GLYPH_ROM;
        end
    end

    // Font ROM, registered read on each accepted character
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rom_data_reg <= font_glyph(code_fold[FONT_AW-1:0]);
        end
    end

    // String state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg   <= '0;
            count_reg <= '0;
        end
        else if (take)
        begin
            pen_reg   <= pen_next;
            count_reg <= count_next;
        end
    end

    // Stage register next to the ROM output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pen_reg   <= pen_use;
            s1_oy_reg    <= cfg.origin_y;
            s1_sc_reg    <= cfg.pixel_scale;
            s1_color_reg <= cfg.draw_color;
            s1_src_reg   <= src;
            s1_drop_reg  <= drop;
        end
    end

    always_comb
    begin
        job.valid       = s1_valid_reg;
        job.pen_x       = s1_pen_reg;
        job.origin_y    = s1_oy_reg;
        job.pixel_scale = s1_sc_reg;
        job.draw_color  = s1_color_reg;
        job.src         = s1_src_reg;
        job.drop        = s1_drop_reg;
        job.glyph       = rom_data_reg;
    end

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.div_busy |-> !char_in.ready)
        else $error("input accepted while fit limit is being computed");

    a_clipped_pen_holds: assert property (@(posedge clk) disable iff (!rst_n)
        take && drop |=> pen_reg == $past(pen_use))
        else $error("pen moved on a clipped character");

    a_take_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted word lost before the emitter");

endmodule

@@ sv/tgr_emit.sv @@
// Square emitter: glyph mask set bits go one per cycle to the output register unless stalled.
// Depends on tgr_pkg and tgr_rect_if.
module tgr_emit
    import tgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  glyph_job_t  job,
    output logic        job_ready,
    tgr_rect_if.source  rect_out
);

    logic [GLYPH_BITS-1:0] mask_reg;
    logic signed [15:0]    pen_reg;
    logic signed [11:0]    oy_reg;
    logic [3:0]            sc_reg;
    logic [31:0]           color_reg;

    logic                  out_valid_reg;
    logic signed [15:0]    out_x_reg;
    logic signed [15:0]    out_y_reg;
    logic [3:0]            out_size_reg;
    logic [31:0]           out_color_reg;
    logic                  out_last_reg;

    logic [GLYPH_BITS-1:0] glyph_sel;
    logic [GLYPH_BITS-1:0] load_mask;
    logic [GLYPH_BITS-1:0] rest;
    logic [GLYPH_BITS-1:0] mask_after;
    logic [ROW_W-1:0]      hit_row;
    logic [COL_W-1:0]      hit_col;
    logic                  fire;
    logic                  load;
    logic [ADV_W-1:0]      col_off, row_off;
    logic signed [16:0]    x_sum;
    logic signed [12:0]    y_sum;

    // Pick the glyph; an empty ROM entry draws the box
    always_comb
    begin
        case (job.src)
            GLYPH_ROM:   glyph_sel = (job.glyph == '0) ? BOX_GLYPH : job.glyph;
            GLYPH_BOX:   glyph_sel = BOX_GLYPH;
            GLYPH_BLANK: glyph_sel = '0;
            default:     glyph_sel = '0;
        endcase
    end

    // Reorder so scan order (row, then column left to right) is ascending bit index
    always_comb
    begin
        load_mask = '0;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            for (int c = 0; c < GLYPH_COLS; c++)
            begin
                load_mask[r*GLYPH_COLS + c] = glyph_sel[r*GLYPH_COLS + GLYPH_COLS - 1 - c];
            end
        end
        if (job.drop)
        begin
            load_mask = '0;
        end
    end

    // Locate the lowest set pixel
    always_comb
    begin
        hit_row = '0;
        hit_col = '0;
        for (int r = GLYPH_ROWS - 1; r >= 0; r--)
        begin
            for (int c = GLYPH_COLS - 1; c >= 0; c--)
            begin
                if (mask_reg[r*GLYPH_COLS + c])
                begin
                    hit_row = ROW_W'(r);
                    hit_col = COL_W'(c);
                end
            end
        end
    end

    assign rest       = mask_reg & (mask_reg - 1'b1);
    assign fire       = (mask_reg != '0) && (!out_valid_reg || rect_out.ready);
    assign mask_after = fire ? rest : mask_reg;
    assign job_ready  = (mask_after == '0);
    assign load       = job.valid && job_ready;

    // Square position; y cannot leave the 16-bit range
    always_comb
    begin
        col_off = ADV_W'(hit_col) * ADV_W'(sc_reg);
        row_off = ADV_W'(hit_row) * ADV_W'(sc_reg);
        x_sum   = {pen_reg[15], pen_reg} + {10'd0, col_off};
        y_sum   = {oy_reg[11], oy_reg} + {6'd0, row_off};
    end

    // Advance the scan or load the next word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (load)
        begin
            mask_reg <= load_mask;
        end
        else
        begin
            mask_reg <= mask_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pen_reg   <= job.pen_x;
            oy_reg    <= job.origin_y;
            sc_reg    <= job.pixel_scale;
            color_reg <= job.draw_color;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rect_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_x_reg     <= sat16(x_sum);
            out_y_reg     <= {{3{y_sum[12]}}, y_sum};
            out_size_reg  <= sc_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= (rest == '0);
        end
    end

    assign rect_out.valid      = out_valid_reg;
    assign rect_out.rect_x     = out_x_reg;
    assign rect_out.rect_y     = out_y_reg;
    assign rect_out.rect_size  = out_size_reg;
    assign rect_out.fill_color = out_color_reg;
    assign rect_out.last_rect  = out_last_reg;

    a_one_pixel_per_word: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !load |=> $countones(mask_reg) + 1 == $past($countones(mask_reg)))
        else $error("scan dropped or repeated a pixel");

    a_stall_holds_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0) && out_valid_reg && !rect_out.ready |=> mask_reg == $past(mask_reg))
        else $error("scan advanced during output stall");

    a_last_frees_emitter: assert property (@(posedge clk) disable iff (!rst_n)
        fire && rest == '0 && !job.valid |=> mask_reg == '0 && rect_out.last_rect)
        else $error("final square not flagged or emitter not freed");

endmodule

@@ sv/text_glyph_rect_generator_unit.sv @@
// A character's squares pass the front stage, the scan mask and the output registers.
// Throughput: one square per cycle unless the output stalls; a character holds the emitter
// until its set pixels (up to 35) are out; blank, clipped and pixel-free characters pass at
// one per cycle. A pixel_scale or fit width write runs the fit-limit divider, input held.
// Reset (rst_n, async low) restores register defaults, pen 0, count 0 and empties the pipe.
module text_glyph_rect_generator_unit
    import tgr_pkg::*;
#(
    parameter int CLIP_BUFFER = CLIP_BUFFER_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    tgr_char_if.sink           char_in,
    tgr_rect_if.source         rect_out
);

    cfg_t       cfg;
    glyph_job_t job;
    logic       job_ready;

    tgr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgr_front #(
        .CLIP_BUFFER (CLIP_BUFFER)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .cfg       (cfg),
        .job       (job),
        .job_ready (job_ready)
    );

    tgr_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (job),
        .job_ready (job_ready),
        .rect_out  (rect_out)
    );

endmodule

@@ dv/text_glyph_rect_generator_unit_tb.sv @@
// Self-checking testbench for text_glyph_rect_generator_unit: APB register setup,
// character stream stimulus, square-by-square comparison against an internal glyph predictor.
// Depends on tgr_pkg, tgr_char_if, tgr_rect_if and the unit itself.
module text_glyph_rect_generator_unit_tb;
    import tgr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_SET = 16;
    localparam int SETS_PER_MODE = 4;

    // Row r of a glyph sits at index r; bit (4 - col) is column col
    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [3:0]         size;
        logic [31:0]        color;
        logic               is_last;
    } square_t;

    // Predicts the squares of each accepted character and checks them in order
    class square_tracker;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [3:0]         pixel_scale;
        logic               fit_enable;
        logic [11:0]        avail_width;
        logic [31:0]        draw_color;
        logic signed [15:0] pen_x;
        logic [COUNT_W-1:0] char_count;
        square_t            pending_squares[$];
        int                 errors;
        int                 chars_seen;
        int                 squares_checked;

        function new();
            origin_x        = '0;
            origin_y        = '0;
            pixel_scale     = 4'd1;
            fit_enable      = 1'b0;
            avail_width     = '0;
            draw_color      = 32'hFFFF_FFFF;
            pen_x           = '0;
            char_count      = '0;
            errors          = 0;
            chars_seen      = 0;
            squares_checked = 0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
            case (idx)
                REG_ORIGIN_X:    origin_x    = value[11:0];
                REG_ORIGIN_Y:    origin_y    = value[11:0];
                REG_PIXEL_SCALE: pixel_scale = value[3:0];
                REG_FIT_ENABLE:  fit_enable  = value[0];
                REG_AVAIL_WIDTH: avail_width = value[11:0];
                REG_DRAW_COLOR:  draw_color  = value;
                default: ;
            endcase
        endfunction

        function logic signed [15:0] clamp16(input int v);
            if (v > 32767)
            begin
                return 16'sh7fff;
            end
            if (v < -32768)
            begin
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function glyph_t rows(input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
                              input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
                              input logic [4:0] r6);
            return {r6, r5, r4, r3, r2, r1, r0};
        endfunction

        // Font contents indexed by upper-case code; anything unlisted is empty
        function glyph_t font_rows(input logic [6:0] code);
            case (code)
                7'h30: return rows(14, 17, 19, 21, 25, 17, 14);
                7'h31: return rows(4, 12, 4, 4, 4, 4, 14);
                7'h32: return rows(14, 17, 1, 2, 4, 8, 31);
                7'h33: return rows(30, 1, 1, 14, 1, 1, 30);
                7'h34: return rows(2, 6, 10, 18, 31, 2, 2);
                7'h35: return rows(31, 16, 30, 1, 1, 17, 14);
                7'h36: return rows(6, 8, 16, 30, 17, 17, 14);
                7'h37: return rows(31, 1, 2, 4, 8, 8, 8);
                7'h38: return rows(14, 17, 17, 14, 17, 17, 14);
                7'h39: return rows(14, 17, 17, 15, 1, 2, 12);
                7'h41: return rows(14, 17, 17, 31, 17, 17, 17);
                7'h42: return rows(30, 17, 17, 30, 17, 17, 30);
                7'h43: return rows(14, 17, 16, 16, 16, 17, 14);
                7'h44: return rows(30, 17, 17, 17, 17, 17, 30);
                7'h45: return rows(31, 16, 16, 30, 16, 16, 31);
                7'h46: return rows(31, 16, 16, 30, 16, 16, 16);
                7'h47: return rows(14, 17, 16, 23, 17, 17, 15);
                7'h48: return rows(17, 17, 17, 31, 17, 17, 17);
                7'h49: return rows(14, 4, 4, 4, 4, 4, 14);
                7'h4A: return rows(7, 2, 2, 2, 18, 18, 12);
                7'h4B: return rows(17, 18, 20, 24, 20, 18, 17);
                7'h4C: return rows(16, 16, 16, 16, 16, 16, 31);
                7'h4D: return rows(17, 27, 21, 21, 17, 17, 17);
                7'h4E: return rows(17, 25, 21, 19, 17, 17, 17);
                7'h4F: return rows(14, 17, 17, 17, 17, 17, 14);
                7'h50: return rows(30, 17, 17, 30, 16, 16, 16);
                7'h51: return rows(14, 17, 17, 17, 21, 18, 13);
                7'h52: return rows(30, 17, 17, 30, 20, 18, 17);
                7'h53: return rows(15, 16, 16, 14, 1, 1, 30);
                7'h54: return rows(31, 4, 4, 4, 4, 4, 4);
                7'h55: return rows(17, 17, 17, 17, 17, 17, 14);
                7'h56: return rows(17, 17, 17, 17, 17, 10, 4);
                7'h57: return rows(17, 17, 17, 21, 21, 21, 10);
                7'h58: return rows(17, 17, 10, 4, 10, 17, 17);
                7'h59: return rows(17, 17, 10, 4, 4, 4, 4);
                7'h5A: return rows(31, 1, 2, 4, 8, 16, 31);
                7'h3F: return rows(14, 17, 1, 2, 4, 0, 4);
                7'h2E: return rows(0, 0, 0, 0, 0, 12, 12);
                7'h2F: return rows(1, 1, 2, 4, 8, 16, 16);
                7'h5C: return rows(16, 16, 8, 4, 2, 1, 1);
                7'h2B: return rows(0, 4, 4, 31, 4, 4, 0);
                7'h2D: return rows(0, 0, 0, 31, 0, 0, 0);
                7'h5F: return rows(0, 0, 0, 0, 0, 0, 31);
                7'h3A: return rows(0, 12, 12, 0, 12, 12, 0);
                7'h26: return rows(12, 18, 20, 8, 21, 18, 13);
                7'h5B: return rows(14, 8, 8, 8, 8, 8, 14);
                7'h5D: return rows(14, 2, 2, 2, 2, 2, 14);
                7'h28: return rows(2, 4, 8, 8, 8, 4, 2);
                7'h29: return rows(8, 4, 2, 2, 2, 4, 8);
                7'h3C: return rows(2, 4, 8, 16, 8, 4, 2);
                7'h3E: return rows(8, 4, 2, 1, 2, 4, 8);
                7'h3D: return rows(0, 0, 31, 0, 31, 0, 0);
                7'h2C: return rows(0, 0, 0, 0, 12, 4, 8);
                default: return '0;
            endcase
        endfunction

        // Fold to upper case, then fall back to the box for unknown or empty codes
        function glyph_t pick_glyph(input logic [7:0] code);
            logic [7:0] ch;
            glyph_t     g;
            ch = code;
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            begin
                ch = ch - CASE_FOLD;
            end
            if (ch >= CH_SPAN)
            begin
                return rows(31, 17, 5, 2, 4, 0, 4);
            end
            if (ch == CH_SPACE)
            begin
                return '0;
            end
            g = font_rows(ch[6:0]);
            if (g == '0)
            begin
                return rows(31, 17, 5, 2, 4, 0, 4);
            end
            return g;
        endfunction

        function void predict_squares(input logic [7:0] code, input logic start);
            int         pos;
            int         limit;
            int         sc;
            int         queued;
            logic [7:0] ch;
            glyph_t     g;
            square_t    sq;
            chars_seen++;
            if (start)
            begin
                pen_x      = 16'(origin_x);
                char_count = '0;
            end
            pos = int'(char_count);
            if (char_count != COUNT_MAX)
            begin
                char_count = char_count + 1'b1;
            end
            sc = int'(pixel_scale);
            ch = code;
            // Clip the string in fit mode; for limits over one the last slot shows the marker
            if (fit_enable)
            begin
                if (avail_width == 0 || pixel_scale == 0)
                begin
                    return;
                end
                limit = int'(avail_width) / (6 * sc);
                if (limit == 0)
                begin
                    return;
                end
                if (limit > CLIP_BUFFER_DEF - 1)
                begin
                    limit = CLIP_BUFFER_DEF - 1;
                end
                if (pos >= limit)
                begin
                    return;
                end
                if (pos == limit - 1 && limit > 1)
                begin
                    ch = CH_MARKER;
                end
            end
            g = pick_glyph(ch);
            queued = pending_squares.size();
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                for (int c = 0; c < GLYPH_COLS; c++)
                begin
                    if (g[r][GLYPH_COLS-1-c])
                    begin
                        sq.x       = clamp16(int'(pen_x) + c * sc);
                        sq.y       = clamp16(int'(origin_y) + r * sc);
                        sq.size    = pixel_scale;
                        sq.color   = draw_color;
                        sq.is_last = 1'b0;
                        pending_squares.push_back(sq);
                    end
                end
            end
            if (pending_squares.size() > queued)
            begin
                pending_squares[pending_squares.size()-1].is_last = 1'b1;
            end
            pen_x = clamp16(int'(pen_x) + 6 * sc);
        endfunction

        function void check_square(input square_t got);
            square_t want;
            if (pending_squares.size() == 0)
            begin
                $error("unexpected square: rect_x %0d rect_y %0d", got.x, got.y);
                errors++;
                return;
            end
            want = pending_squares.pop_front();
            squares_checked++;
            if (got.x !== want.x)
            begin
                $error("rect_x mismatch: expected %0d, actual %0d", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y)
            begin
                $error("rect_y mismatch: expected %0d, actual %0d", want.y, got.y);
                errors++;
            end
            if (got.size !== want.size)
            begin
                $error("rect_size mismatch: expected %0d, actual %0d", want.size, got.size);
                errors++;
            end
            if (got.color !== want.color)
            begin
                $error("fill_color mismatch: expected %h, actual %h", want.color, got.color);
                errors++;
            end
            if (got.is_last !== want.is_last)
            begin
                $error("last_rect mismatch: expected %0b, actual %0b", want.is_last, got.is_last);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               rx_ready = 1'b0;
    int                 tx_idle_pct;
    int                 rx_stall_pct;
    int                 cycle_count;
    int                 settings_applied;
    square_tracker      sb;

    tgr_char_if char_bus ();
    tgr_rect_if rect_bus ();

    assign rect_bus.ready = rx_ready;

    text_glyph_rect_generator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .char_in  (char_bus),
        .rect_out (rect_bus)
    );

    always #2 clk = ~clk;

    // Stall the square channel at random
    always @(posedge clk)
    begin
        rx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Predict on each accepted character word, check each accepted square word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                sb.predict_squares(char_bus.char_code, char_bus.string_start);
            end
            if (rect_bus.valid && rect_bus.ready)
            begin
                sb.check_square({rect_bus.rect_x, rect_bus.rect_y, rect_bus.rect_size,
                                 rect_bus.fill_color, rect_bus.last_rect});
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Drop valid, wait for every predicted square, then let the pipe empty
    task automatic settle();
        char_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_squares.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_char(input logic [7:0] code, input logic start);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid        <= 1'b1;
        char_bus.char_code    <= code;
        char_bus.string_start <= start;
        @(posedge clk);
        while (!char_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apply_settings(input logic [31:0] ox, input logic [31:0] oy,
                                  input logic [31:0] sc, input logic [31:0] fit,
                                  input logic [31:0] mw, input logic [31:0] color);
        settle();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_PIXEL_SCALE, sc);
        write_reg(REG_FIT_ENABLE, fit);
        write_reg(REG_AVAIL_WIDTH, mw);
        write_reg(REG_DRAW_COLOR, color);
        settings_applied++;
    endtask

    function automatic logic [7:0] random_char();
        logic [7:0] punct [0:16] = '{8'h3F, 8'h2E, 8'h2F, 8'h5C, 8'h2B, 8'h2D, 8'h5F, 8'h3A,
                                     8'h26, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h3C, 8'h3E, 8'h3D,
                                     8'h2C};
        case ($urandom_range(0, 9))
            0, 1:    return 8'h41 + 8'($urandom_range(0, 25));
            2:       return 8'h61 + 8'($urandom_range(0, 25));
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            4:       return punct[$urandom_range(0, 16)];
            5:       return CH_SPACE;
            6, 7:    return 8'($urandom_range(1, 255));
            8:       return 8'($urandom_range(1, 95));
            default: return 8'($urandom_range(96, 255));
        endcase
    endfunction

    // Widths that clip a short string half the time, plus the register extremes
    task automatic randomize_settings();
        logic [31:0] ox;
        logic [31:0] oy;
        logic [31:0] sc;
        logic [31:0] mw;
        logic [31:0] color;
        int          step;
        case ($urandom_range(0, 3))
            0:       ox = 32'h800;
            1:       ox = 32'h7FF;
            default: ox = $urandom_range(0, 4095);
        endcase
        case ($urandom_range(0, 3))
            0:       oy = 32'h800;
            1:       oy = 32'h7FF;
            default: oy = $urandom_range(0, 4095);
        endcase
        sc = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(1, 15));
        step = (sc == 0) ? 6 : 6 * int'(sc);
        case ($urandom_range(0, 5))
            0:       mw = 32'd0;
            1:       mw = 32'd4095;
            2:       mw = $urandom_range(0, 4095);
            default: mw = step * $urandom_range(1, 8) + $urandom_range(0, 5);
        endcase
        if (mw > 4095)
        begin
            mw = 4095;
        end
        case ($urandom_range(0, 3))
            0:       color = 32'h0000_0000;
            1:       color = 32'hFFFF_FFFF;
            default: color = $urandom;
        endcase
        apply_settings(ox, oy, sc, 32'($urandom_range(0, 1)), mw, color);
    endtask

    initial
    begin
        int sent;
        int len;
        sb = new();
        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        char_bus.valid        <= 1'b0;
        char_bus.char_code    <= 8'h41;
        char_bus.string_start <= 1'b0;
        cycle_count           <= 0;
        settings_applied      = 0;
        tx_idle_pct           = 32;
        rx_stall_pct          = 56;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings, no string start yet: pen continues from zero
        send_char(8'h41, 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h7A, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h60, 1'b0);
        send_char(8'h01, 1'b0);
        send_char(CH_SPACE, 1'b0);
        send_char(8'h30, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'h7E, 1'b0);

        // Coordinate and color extremes, largest scale
        apply_settings(32'h800, 32'h7FF, 32'd15, 32'd0, 32'd4095, 32'h0000_0000);
        send_char(8'h38, 1'b1);
        send_char(8'h7B, 1'b0);

        // Zero scale outside fit mode: size-zero squares stacked at the pen
        apply_settings(32'h7FF, 32'h800, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_char(8'h57, 1'b1);
        send_char(8'h62, 1'b0);

        // Fit limit of five: four glyphs, the marker, then dropped characters
        apply_settings(32'd10, 32'd20, 32'd2, 32'd1, 32'd60, 32'h1234_5678);
        send_char(8'h48, 1'b1);
        send_char(8'h45, 1'b0);
        send_char(8'h4C, 1'b0);
        send_char(8'h4C, 1'b0);
        send_char(8'h4F, 1'b0);
        send_char(8'h58, 1'b0);
        send_char(8'h59, 1'b0);

        // Fit limit of one keeps the glyph without a marker
        apply_settings(32'd0, 32'd0, 32'd1, 32'd1, 32'd6, 32'hA5A5_5A5A);
        send_char(8'h51, 1'b1);
        send_char(8'h52, 1'b0);

        // Zero limit from the quotient, from zero width and from zero scale
        apply_settings(32'd0, 32'd0, 32'd1, 32'd1, 32'd5, 32'hA5A5_5A5A);
        send_char(8'h4B, 1'b1);
        apply_settings(32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'hA5A5_5A5A);
        send_char(8'h4B, 1'b1);
        apply_settings(32'd0, 32'd0, 32'd0, 32'd1, 32'd4095, 32'hA5A5_5A5A);
        send_char(8'h4B, 1'b1);

        // Random strings under three idling modes
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct  = (mode == 0) ? 32 : (mode == 1) ? 56 : 0;
            rx_stall_pct = (mode == 0) ? 56 : (mode == 1) ? 32 : 0;
            for (int s = 0; s < SETS_PER_MODE; s++)
            begin
                randomize_settings();
                sent = 0;
                while (sent < ITEMS_PER_SET)
                begin
                    len = $urandom_range(1, 12);
                    // Most strings open with a start flag; a few continue the last one
                    send_char(random_char(), ($urandom_range(0, 9) != 0));
                    for (int k = 1; k < len; k++)
                    begin
                        send_char(random_char(), ($urandom_range(0, 29) == 0));
                    end
                    sent += len;
                end
            end
        end

        settle();
        $display("Covered %0d characters and %0d squares over %0d register settings",
                 sb.chars_seen, sb.squares_checked, settings_applied);
        $display("Fit clipping, zero limits, zero and largest scale and all idling modes exercised");
        if (sb.errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
